/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the reorder block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ioc_pkg.sv */
// Package with shared types and constants of the in-order completion reorder block.
`timescale 1ns / 1ps
package ioc_pkg;

  localparam int TAG_PORT_W = 16;
  localparam int SEQ_PORT_W = 32;
  localparam int TDATA_W    = TAG_PORT_W + SEQ_PORT_W;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_ORDERING_ENABLE = 3'd0;

  typedef enum logic {
    ST_IDLE,
    ST_CHAIN
  } state_t;

endpackage

/* sv/ioc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ioc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ioc_front.sv */
// Front end: accepts completions, trims them to the working widths, queues them.
`timescale 1ns / 1ps
module ioc_front #(
  parameter int SEQ_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ordering_enable,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ioc_pkg::TDATA_W-1:0] s_tdata,
  output logic                       q_valid,
  output logic [TAG_BITS-1:0]        q_tag,
  output logic [SEQ_BITS-1:0]        q_seq,
  output logic                       q_pass,
  input  logic                       q_pop
);

  localparam logic [1:0] QDEPTH = 2'd2;

  logic [TAG_BITS-1:0] tag_q  [2];
  logic [SEQ_BITS-1:0] seq_q  [2];
  logic                pass_q [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;
  logic                pop;

  assign s_tready = (count != QDEPTH);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && q_valid;

  assign q_valid = (count != 2'd0);
  assign q_tag   = tag_q[rd_ptr];
  assign q_seq   = seq_q[rd_ptr];
  assign q_pass  = pass_q[rd_ptr];

  // Tag the item with the mode in force; the user must change the mode only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (push) begin
      tag_q[wr_ptr]  <= TAG_BITS'(s_tdata[ioc_pkg::TAG_PORT_W-1:0]);
      seq_q[wr_ptr]  <= SEQ_BITS'(s_tdata[ioc_pkg::TDATA_W-1:ioc_pkg::TAG_PORT_W]);
      pass_q[wr_ptr] <= !ordering_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/ioc_back.sv */
// Back end: hold store, release chain and output register.
`timescale 1ns / 1ps
module ioc_back #(
  parameter int HOLD_DEPTH = 16,
  parameter int SEQ_BITS   = 32,
  parameter int TAG_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  logic [TAG_BITS-1:0]         q_tag,
  input  logic [SEQ_BITS-1:0]         q_seq,
  input  logic                        q_pass,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ioc_pkg::TDATA_W-1:0] m_tdata,
  output logic                        m_tlast,
  output logic                        m_tuser
);

  localparam int IDX_W = $clog2(HOLD_DEPTH);

  ioc_pkg::state_t state, state_next;

  logic [SEQ_BITS-1:0] last_done;
  logic [SEQ_BITS-1:0] want;
  logic [HOLD_DEPTH-1:0] hold_valid;
  logic [SEQ_BITS-1:0] hold_seq [HOLD_DEPTH];

  logic                hit_any;
  logic [IDX_W-1:0]    hit_idx;
  logic                free_any;
  logic [IDX_W-1:0]    free_idx;

  logic                tag_from_ram;
  logic [TAG_BITS-1:0] pending_tag;
  logic [TAG_BITS-1:0] ram_rdata;
  logic [TAG_BITS-1:0] cur_tag;

  logic                out_can;
  logic                emit;
  logic [TAG_BITS-1:0] e_tag;
  logic [SEQ_BITS-1:0] e_seq;
  logic                e_last;
  logic                e_ovf;
  logic                park;
  logic                take;
  logic                start_chain;
  logic                ld_done;
  logic [SEQ_BITS-1:0] done_val;

  logic                out_valid;
  logic [ioc_pkg::TAG_PORT_W-1:0] out_tag;
  logic [ioc_pkg::SEQ_PORT_W-1:0] out_seq;
  logic                out_last;
  logic                out_ovf;

  assign want    = last_done + SEQ_BITS'(1);
  assign out_can = !out_valid || m_tready;
  assign cur_tag = tag_from_ram ? ram_rdata : pending_tag;

  // Match lines: lowest-indexed valid entry holding the wanted number,
  // and the lowest-indexed free slot.
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = HOLD_DEPTH - 1; i >= 0; i--) begin
      if (hold_valid[i] && (hold_seq[i] == want)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!hold_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ioc_pkg::ST_IDLE: begin
        if (q_valid && !q_pass && (q_seq == want)) begin
          state_next = ioc_pkg::ST_CHAIN;
        end
      end
      ioc_pkg::ST_CHAIN: begin
        if (out_can && !hit_any) begin
          state_next = ioc_pkg::ST_IDLE;
        end
      end
      default: state_next = ioc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    emit        = 1'b0;
    e_tag       = q_tag;
    e_seq       = q_seq;
    e_last      = 1'b1;
    e_ovf       = 1'b0;
    park        = 1'b0;
    take        = 1'b0;
    start_chain = 1'b0;
    ld_done     = 1'b0;
    done_val    = q_seq;
    case (state)
      ioc_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_pass) begin
            if (out_can) begin
              emit    = 1'b1;
              q_pop   = 1'b1;
              ld_done = 1'b1;
            end
          end else if (q_seq == want) begin
            q_pop       = 1'b1;
            start_chain = 1'b1;
            ld_done     = 1'b1;
          end else if (free_any) begin
            park  = 1'b1;
            q_pop = 1'b1;
          end else if (out_can) begin
            emit  = 1'b1;
            e_ovf = 1'b1;
            q_pop = 1'b1;
          end
        end
      end
      ioc_pkg::ST_CHAIN: begin
        if (out_can) begin
          emit   = 1'b1;
          e_tag  = cur_tag;
          e_seq  = last_done;
          e_last = !hit_any;
          if (hit_any) begin
            take     = 1'b1;
            ld_done  = 1'b1;
            done_val = want;
          end
        end
      end
      default: begin
      end
    endcase
  end

  ioc_ram #(
    .WIDTH(TAG_BITS),
    .DEPTH(HOLD_DEPTH)
  ) u_tag_ram (
    .clk  (clk),
    .we   (park),
    .waddr(free_idx),
    .wdata(q_tag),
    .raddr(hit_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (park) begin
      hold_seq[free_idx] <= q_seq;
    end
    if (start_chain) begin
      pending_tag <= q_tag;
    end else if (tag_from_ram) begin
      pending_tag <= ram_rdata;
    end
    if (emit) begin
      out_tag  <= ioc_pkg::TAG_PORT_W'(e_tag);
      out_seq  <= ioc_pkg::SEQ_PORT_W'(e_seq);
      out_last <= e_last;
      out_ovf  <= e_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ioc_pkg::ST_IDLE;
      last_done    <= '0;
      hold_valid   <= '0;
      tag_from_ram <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      tag_from_ram <= take;
      if (ld_done) begin
        last_done <= done_val;
      end
      if (park) begin
        hold_valid[free_idx] <= 1'b1;
      end
      if (take) begin
        hold_valid[hit_idx] <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_seq, out_tag};
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

endmodule

/* sv/in_order_completion_reorder.sv */
// Top level of the in-order completion reorder block.
//
//  Channel  Direction  Contents
//  s_*      in         completion: tdata = item_tag[15:0], seq_number[47:16]
//  m_*      out        release: tdata = out_tag[15:0], out_seq[47:16];
//                      tlast = last, tuser = overflow
//  APB      in/out     register 0 at 0x0: ordering_enable (bit 0)
//
// Flow: pass-through, parked and overflow items pass the back end one at a
// time; an in-order item enters the chain, which then releases one result per
// cycle while the output can take it, so the single-match chain loop sets throughput.
// Reset: rst is synchronous, active high; it clears the queue, the hold
// valid bits, last completed number and the output register.
// Stalls: a two-entry queue lets the input side keep filling while the
// back end waits on m_tready; the output register holds until transfer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module in_order_completion_reorder #(
  parameter int HOLD_DEPTH = 16,
  parameter int SEQ_BITS   = 32,
  parameter int TAG_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // completion in: item_tag[15:0], seq_number[47:16]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ioc_pkg::TDATA_W-1:0]    s_tdata,
  // release out: out_tag[15:0], out_seq[47:16]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ioc_pkg::TDATA_W-1:0]    m_tdata,
  output logic                           m_tlast,
  // overflow[0]
  output logic                           m_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ioc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ioc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ioc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic                ordering_enable;
  logic                q_valid;
  logic [TAG_BITS-1:0] q_tag;
  logic [SEQ_BITS-1:0] q_seq;
  logic                q_pass;
  logic                q_pop;

  // Register file: one mode bit, written on the APB access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ordering_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr == ioc_pkg::ADDR_ORDERING_ENABLE)) begin
      ordering_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ioc_pkg::ADDR_ORDERING_ENABLE) begin
      prdata[0] = ordering_enable;
    end
  end

  // Front: accept and queue completions.
  ioc_front #(
    .SEQ_BITS(SEQ_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .ordering_enable(ordering_enable),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .q_valid        (q_valid),
    .q_tag          (q_tag),
    .q_seq          (q_seq),
    .q_pass         (q_pass),
    .q_pop          (q_pop)
  );

  // Back: park, drop or release, then walk the chain of held numbers.
  ioc_back #(
    .HOLD_DEPTH(HOLD_DEPTH),
    .SEQ_BITS  (SEQ_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_tag   (q_tag),
    .q_seq   (q_seq),
    .q_pass  (q_pass),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  // A dropped item always ends its run.
  `ASSERT_IMPLIES(a_ovf_last, m_tvalid && m_tuser, m_tlast, "overflow result without last")
  // With ordering off every completion is its own run.
  `ASSERT_IMPLIES(a_pass_last, m_tvalid && !ordering_enable, m_tlast, "pass result without last")
  // A chain never leaves a gap after a non-final release is transferred.
  `ASSERT_NEXT(a_chain_cont, m_tvalid && m_tready && !m_tlast, m_tvalid, "chain stalled")

endmodule

/* verif/in_order_completion_reorder_test.sv */
// Self-checking testbench of the in-order completion reorder block.
`timescale 1ns / 1ps
module in_order_completion_reorder_test;

  localparam int CLK_HALF_NS    = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_SLOTS     = 16;
  // Parked items still pass the back end behind a two-entry queue; allow plenty.
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SEGMENTS       = 8;
  localparam int SEGMENT_ITEMS  = 48;
  localparam int RUN_LIMIT_NS   = 4_000_000;

  // Register index 4 does not exist; writes there must be dropped.
  localparam logic [ioc_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] seq;
    logic        last;
    logic        ovf;
  } release_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_WRITE
  } row_kind_t;

  // One row of the directed script. Item rows send count completions with
  // tag and seq stepping by one; typed rows carry their single result.
  typedef struct packed {
    row_kind_t                         kind;
    logic [ioc_pkg::APB_ADDR_W-1:0]    addr;
    logic [ioc_pkg::APB_DATA_W-1:0]    wdata;
    logic [7:0]                        count;
    logic [15:0]                       tag;
    logic [31:0]                       seq;
    logic                              typed;
    release_t                          result;
  } stim_row_t;

  localparam release_t UNTYPED     = '0;
  localparam int       SCRIPT_ROWS = 15;

  stim_row_t script [SCRIPT_ROWS] = '{
    // ordering off after reset: both extremes pass straight through
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0000, 32'h0000_0000, 1'b1,
      '{16'h0000, 32'h0000_0000, 1'b1, 1'b0}},
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}},
    // unknown register: must leave ordering off (checked on readback)
    '{ROW_WRITE, ADDR_UNMAPPED, 32'd1, 8'd0, 16'h0, 32'h0, 1'b0, UNTYPED},
    '{ROW_WRITE, ioc_pkg::ADDR_ORDERING_ENABLE, 32'd1, 8'd0, 16'h0, 32'h0, 1'b0, UNTYPED},
    // last completed is all ones, so zero is next: wrap
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'hA5A5, 32'h0000_0000, 1'b1,
      '{16'hA5A5, 32'h0000_0000, 1'b1, 1'b0}},
    // reverse arrival: 3 and 2 park, 1 releases the chain 1,2,3
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0003, 32'd3, 1'b0, UNTYPED},
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0002, 32'd2, 1'b0, UNTYPED},
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0001, 32'd1, 1'b0, UNTYPED},
    // two parked entries share number 5: the lower slot goes first, the
    // other stays behind as a stale duplicate
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0051, 32'd5, 1'b0, UNTYPED},
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0052, 32'd5, 1'b0, UNTYPED},
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0004, 32'd4, 1'b0, UNTYPED},
    // fill the remaining fifteen slots, then overflow echoes the dropped item
    '{ROW_ITEM, '0, 32'd0, 8'd15, 16'h0101, 32'd101, 1'b0, UNTYPED},
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0BAD, 32'd200, 1'b1,
      '{16'h0BAD, 32'd200, 1'b1, 1'b1}},
    // pass-through with ordering off moves the last number but keeps the store
    '{ROW_WRITE, ioc_pkg::ADDR_ORDERING_ENABLE, 32'd0, 8'd0, 16'h0, 32'h0, 1'b0, UNTYPED},
    '{ROW_ITEM, '0, 32'd0, 8'd1, 16'h0099, 32'd99, 1'b1,
      '{16'h0099, 32'd99, 1'b1, 1'b0}}
  };

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ioc_pkg::TDATA_W-1:0]    s_tdata;   // item_tag[15:0], seq_number[47:16]
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [ioc_pkg::TDATA_W-1:0]    m_tdata;   // out_tag[15:0], out_seq[47:16]
  logic                           m_tlast;
  logic                           m_tuser;   // overflow[0]
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ioc_pkg::APB_ADDR_W-1:0] paddr;
  logic [ioc_pkg::APB_DATA_W-1:0] pwdata;
  logic [ioc_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // Predicted block state.
  logic        ordering_on = 1'b0;
  logic [31:0] last_done   = '0;
  logic        slot_busy [HOLD_SLOTS];
  logic [31:0] slot_seq  [HOLD_SLOTS];
  logic [15:0] slot_tag  [HOLD_SLOTS];

  release_t expected_releases [$];
  release_t oldest;
  int       mismatch_count     = 0;
  int       items_offered      = 0;
  int       sender_idle_pct    = 0;
  int       receiver_stall_pct = 0;
  bit       holdoff_req        = 1'b0;
  int       holdoff_left       = 0;

  in_order_completion_reorder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("MISMATCH at %0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Work out the releases one accepted completion causes and queue them.
  function automatic void order_completion(input logic [15:0] tag, input logic [31:0] seq);
    release_t    carry;
    logic [31:0] want;
    bit          found;
    bit          parked;
    if (!ordering_on) begin
      last_done = seq;
      expected_releases.push_back('{tag, seq, 1'b1, 1'b0});
      return;
    end
    if (seq != last_done + 32'd1) begin
      // Out of order (also stale or duplicate): park in the lowest free slot.
      parked = 1'b0;
      for (int i = 0; i < HOLD_SLOTS; i++) begin
        if (!parked && !slot_busy[i]) begin
          slot_busy[i] = 1'b1;
          slot_seq[i]  = seq;
          slot_tag[i]  = tag;
          parked       = 1'b1;
        end
      end
      if (!parked)
        expected_releases.push_back('{tag, seq, 1'b1, 1'b1});
      return;
    end
    // In order: release it, then pull the next number out of the store
    // one match at a time until the chain breaks.
    last_done = seq;
    carry     = '{tag, seq, 1'b0, 1'b0};
    do begin
      want  = last_done + 32'd1;
      found = 1'b0;
      for (int i = 0; i < HOLD_SLOTS; i++) begin
        if (!found && slot_busy[i] && slot_seq[i] == want) begin
          slot_busy[i] = 1'b0;
          last_done    = want;
          expected_releases.push_back(carry);
          carry = '{slot_tag[i], want, 1'b0, 1'b0};
          found = 1'b1;
        end
      end
    end while (found);
    carry.last = 1'b1;
    expected_releases.push_back(carry);
  endfunction

  // Offer one completion, with random idle cycles ahead of it, and hold it
  // until the transfer. Typed rows replace the prediction by their own result.
  task automatic offer_completion(input logic [15:0] tag, input logic [31:0] seq,
                                  input logic typed, input release_t result);
    int       pending_before;
    release_t discard;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {seq, tag};
    do @(posedge clk); while (!s_tready);
    items_offered++;
    pending_before = expected_releases.size();
    order_completion(tag, seq);
    if (typed) begin
      while (expected_releases.size() > pending_before)
        discard = expected_releases.pop_back();
      expected_releases.push_back(result);
    end
  endtask

  // Drop valid and wait for every pending release, then let any parked item
  // finish inside the block before the next register write.
  task automatic drain_releases();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (expected_releases.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_releases.size() != 0) begin
      report_mismatch("releases never delivered", '0, expected_releases.size());
      expected_releases.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read ordering_enable back in a second transfer
  // with psel held high.
  task automatic configure_register(input logic [ioc_pkg::APB_ADDR_W-1:0] addr,
                                    input logic [ioc_pkg::APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ioc_pkg::ADDR_ORDERING_ENABLE)
      ordering_on = value[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ioc_pkg::ADDR_ORDERING_ENABLE;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== {{(ioc_pkg::APB_DATA_W-1){1'b0}}, ordering_on})
      report_mismatch("ordering_enable readback", prdata, ordering_on);
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A run of consecutive numbers from the next expected one, mostly shuffled,
  // with the odd stale or far-off completion mixed in.
  task automatic offer_window();
    logic [31:0] base;
    logic [31:0] order [12];
    logic [31:0] swap;
    logic [31:0] noise;
    int          len;
    int          j;
    base = last_done + 32'd1;
    len  = $urandom_range(1, 12);
    for (int k = 0; k < len; k++)
      order[k] = base + k;
    if ($urandom_range(0, 3) != 0) begin
      for (int k = len - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        swap     = order[k];
        order[k] = order[j];
        order[j] = swap;
      end
    end
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        noise = $urandom_range(0, 1) ? last_done - $urandom_range(0, 3) : $urandom;
        offer_completion(16'($urandom_range(0, 16'hFFFF)), noise, 1'b0, UNTYPED);
      end
      offer_completion(16'($urandom_range(0, 16'hFFFF)), order[k], 1'b0, UNTYPED);
    end
  endtask

  function automatic logic [31:0] pick_seq();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Pass-through segment. Its last number sets up the next ordered segment:
  // two below a parked entry so the chain drains it, else just short of wrap.
  task automatic offer_pass_segment();
    logic [31:0] target;
    bit          found;
    for (int k = 0; k < SEGMENT_ITEMS - 1; k++)
      offer_completion(16'($urandom_range(0, 16'hFFFF)), pick_seq(), 1'b0, UNTYPED);
    target = 32'hFFFF_FFF8 + $urandom_range(0, 7);
    found  = 1'b0;
    for (int i = 0; i < HOLD_SLOTS; i++) begin
      if (!found && slot_busy[i]) begin
        target = slot_seq[i] - 32'd2;
        found  = 1'b1;
      end
    end
    offer_completion(16'($urandom_range(0, 16'hFFFF)), target, 1'b0, UNTYPED);
  endtask

  // Receiver: random stalls, or a long hold-off when the driver asks for one.
  always @(posedge clk) begin
    if (holdoff_req) begin
      holdoff_req  = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Check every release transfer against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_releases.size() == 0) begin
        report_mismatch("release with nothing pending", m_tdata, '0);
      end else begin
        oldest = expected_releases.pop_front();
        if (m_tdata[15:0] !== oldest.tag)
          report_mismatch("out_tag", m_tdata[15:0], oldest.tag);
        if (m_tdata[47:16] !== oldest.seq)
          report_mismatch("out_seq", m_tdata[47:16], oldest.seq);
        if (m_tlast !== oldest.last)
          report_mismatch("last", m_tlast, oldest.last);
        if (m_tuser !== oldest.ovf)
          report_mismatch("overflow", m_tuser, oldest.ovf);
      end
    end
  end

  initial begin
    logic [ioc_pkg::APB_DATA_W-1:0] reg_value;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    for (int i = 0; i < HOLD_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_seq[i]  = '0;
      slot_tag[i]  = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed script, no idling on either side.
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].kind == ROW_WRITE) begin
        drain_releases();
        configure_register(script[r].addr, script[r].wdata);
      end else begin
        for (int k = 0; k < script[r].count; k++)
          offer_completion(16'(script[r].tag + k), 32'(script[r].seq + k),
                           script[r].typed, script[r].result);
      end
    end
    // Ordering back on with 100 next: releases 100 and the fifteen parked
    // numbers behind it in one chain.
    drain_releases();
    configure_register(ioc_pkg::ADDR_ORDERING_ENABLE, 32'd1);
    offer_completion(16'h0100, 32'd100, 1'b0, UNTYPED);

    // Random segments: ordered windows alternate with pass-through runs,
    // stepping through the idling phases.
    for (int s = 0; s < SEGMENTS; s++) begin
      drain_releases();
      case (s % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
        default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
      endcase
      reg_value    = $urandom;
      reg_value[0] = (s % 2 == 0);
      configure_register(ioc_pkg::ADDR_ORDERING_ENABLE, reg_value);
      // Back-pressure: hold the receiver off while items keep coming.
      if (s == 3)
        holdoff_req = 1'b1;
      if (ordering_on) begin
        reg_value = items_offered;
        while (items_offered - reg_value < SEGMENT_ITEMS)
          offer_window();
      end else begin
        offer_pass_segment();
      end
    end
    drain_releases();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
